FILE: design/ascii_hex_frame_checker_assert.svh
// Assertion macros for the ASCII hex frame checker.
// Used by the checker module; expects signals named clk and rst_n in scope.
`ifndef ASCII_HEX_FRAME_CHECKER_ASSERT_SVH
`define ASCII_HEX_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AHFC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ascii_hex_frame_checker: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AHFC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ascii_hex_frame_checker: assertion failed");

`endif

FILE: design/ahfc_pkg.sv
// Shared types, codes and helper function of the ASCII hex frame checker.
// No dependencies; the design files that use it refer to it by scoped names.
package ahfc_pkg;

    localparam logic [7:0] START_CHAR  = 8'h7E;
    localparam logic [7:0] CR_CHAR     = 8'h0D;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam int         QUEUE_DEPTH = 4;

    // Index of the last digit of the header hex run (ADR, CID1, CID2, LEN).
    localparam logic [11:0] HDR_LAST_DIGIT = 12'd9;
    localparam logic [11:0] ADDR_DIGIT     = 12'd1;
    localparam logic [11:0] CID1_DIGIT     = 12'd3;
    localparam logic [11:0] CID2_DIGIT     = 12'd5;
    localparam logic [11:0] CHK_DIGITS     = 12'd4;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_VER1,
        PH_VER2,
        PH_HDR,
        PH_INFO,
        PH_CHK,
        PH_END
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_LEN_BAD = 3'd1,
        ST_CHK_BAD = 3'd2,
        ST_NO_CR   = 3'd3,
        ST_NOT_HEX = 3'd4
    } status_t;

    // A received byte after classification by the front end.
    typedef struct packed {
        logic [7:0] data;
        logic [3:0] hex_val;
        logic       hex_ok;
        logic       is_start;
        logic       is_cr;
    } entry_t;

    // One result item as held in the output register.
    typedef struct packed {
        logic        kind;
        logic [7:0]  info_char;
        status_t     status;
        logic [7:0]  major_version;
        logic [7:0]  minor_version;
        logic [7:0]  device_address;
        logic [7:0]  control_code;
        logic [7:0]  command_code;
        logic [11:0] info_length;
        logic [15:0] received_checksum;
        logic        frame_last;
    } result_t;

    // Returns {valid, value}; characters outside 0-9, A-F, a-f give value zero.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, c[3:0]};
            end
            else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            begin
                r = {1'b1, 4'(c[3:0] + 4'd9)};
            end
            return r;
        end
    endfunction

endpackage

FILE: design/ahfc_if.sv
// Valid/ready channel interfaces for the received byte stream and the results.
// Depends on nothing; payload names match the frame checker's fields.
interface ahfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ahfc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  info_char;
    logic [2:0]  status;
    logic [7:0]  major_version;
    logic [7:0]  minor_version;
    logic [7:0]  device_address;
    logic [7:0]  control_code;
    logic [7:0]  command_code;
    logic [11:0] info_length;
    logic [15:0] received_checksum;
    logic        frame_last;

    modport source (
        output valid, output kind, output info_char, output status,
        output major_version, output minor_version, output device_address,
        output control_code, output command_code, output info_length,
        output received_checksum, output frame_last, input ready
    );
    modport sink (
        input valid, input kind, input info_char, input status,
        input major_version, input minor_version, input device_address,
        input control_code, input command_code, input info_length,
        input received_checksum, input frame_last, output ready
    );
endinterface

FILE: design/ahfc_front.sv
// Front end: takes requests from the byte channel and classifies each byte.
// Depends on ahfc_pkg and ahfc_in_if.
module ahfc_front (
    ahfc_in_if.sink          rx,
    output logic             push_valid,
    input  logic             push_ready,
    output ahfc_pkg::entry_t push_data
);

    logic [4:0] hex_dec;

    assign hex_dec = ahfc_pkg::hex_decode(rx.rx_byte);

    assign push_valid         = rx.valid;
    assign rx.ready           = push_ready;
    assign push_data.data     = rx.rx_byte;
    assign push_data.hex_ok   = hex_dec[4];
    assign push_data.hex_val  = hex_dec[3:0];
    assign push_data.is_start = (rx.rx_byte == ahfc_pkg::START_CHAR);
    assign push_data.is_cr    = (rx.rx_byte == ahfc_pkg::CR_CHAR);

endmodule

FILE: design/ahfc_queue.sv
// Short first-in first-out queue of classified bytes between front and back end.
// Depends on ahfc_pkg for the entry type.
module ahfc_queue #(
    parameter int Depth = ahfc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  ahfc_pkg::entry_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ahfc_pkg::entry_t pop_data
);

    localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

    ahfc_pkg::entry_t slots_reg [Depth];
    logic [IdxW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IdxW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + IdxW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + IdxW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/ahfc_back.sv
// Back end: frame state machine, header decode, checksums and result register.
// Depends on ahfc_pkg and ahfc_out_if.
module ahfc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  ahfc_pkg::entry_t entry,
    ahfc_out_if.source       result
);

    ahfc_pkg::phase_t  phase_reg, phase_next;
    logic [11:0]       digit_pos_reg, digit_pos_next;
    logic [15:0]       hex_acc_reg, hex_acc_next;
    logic [15:0]       run_sum_reg, run_sum_next;
    logic [7:0]        major_reg, major_next;
    logic [7:0]        minor_reg, minor_next;
    logic [7:0]        addr_reg, addr_next;
    logic [7:0]        cid1_reg, cid1_next;
    logic [7:0]        cid2_reg, cid2_next;
    logic [11:0]       ann_len_reg, ann_len_next;
    logic              hex_err_reg, hex_err_next;
    logic              res_valid_reg, res_valid_next;
    ahfc_pkg::result_t res_reg, res_next;

    logic              step;
    logic [15:0]       sum_add;
    logic [15:0]       acc_shift;
    logic              err_now;
    logic [11:0]       dp_inc;
    logic [5:0]        nib_sum;
    logic [3:0]        len_chk;
    logic              len_bad;
    logic              hdr_done;
    logic [15:0]       expect_sum;
    logic              emit_info;
    logic              emit_status;
    ahfc_pkg::status_t status_code;
    logic [15:0]       chk_value;

    // The back end advances whenever the result register is free or drains.
    assign pop_ready  = !res_valid_reg || result.ready;
    assign step       = pop_valid && pop_ready;

    assign sum_add    = run_sum_reg + {8'd0, entry.data};
    assign acc_shift  = {hex_acc_reg[11:0], entry.hex_val};
    assign err_now    = hex_err_reg || !entry.hex_ok;
    assign dp_inc     = digit_pos_reg + 12'd1;
    assign nib_sum    = {2'b00, acc_shift[3:0]} + {2'b00, acc_shift[7:4]}
                      + {2'b00, acc_shift[11:8]};
    assign len_chk    = 4'd0 - nib_sum[3:0];
    assign len_bad    = (acc_shift[15:12] != len_chk);
    assign hdr_done   = (digit_pos_reg >= ahfc_pkg::HDR_LAST_DIGIT);
    assign expect_sum = 16'd0 - run_sum_reg;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                ahfc_pkg::PH_HUNT:
                begin
                    if (entry.is_start)
                    begin
                        phase_next = ahfc_pkg::PH_VER1;
                    end
                end
                ahfc_pkg::PH_VER1: phase_next = ahfc_pkg::PH_VER2;
                ahfc_pkg::PH_VER2: phase_next = ahfc_pkg::PH_HDR;
                ahfc_pkg::PH_HDR:
                begin
                    if (hdr_done)
                    begin
                        if (err_now || len_bad)
                        begin
                            phase_next = ahfc_pkg::PH_HUNT;
                        end
                        else if (acc_shift[11:0] == 12'd0)
                        begin
                            phase_next = ahfc_pkg::PH_CHK;
                        end
                        else
                        begin
                            phase_next = ahfc_pkg::PH_INFO;
                        end
                    end
                end
                ahfc_pkg::PH_INFO:
                begin
                    if (dp_inc >= ann_len_reg)
                    begin
                        phase_next = ahfc_pkg::PH_CHK;
                    end
                end
                ahfc_pkg::PH_CHK:
                begin
                    if (dp_inc >= ahfc_pkg::CHK_DIGITS)
                    begin
                        phase_next = ahfc_pkg::PH_END;
                    end
                end
                ahfc_pkg::PH_END: phase_next = ahfc_pkg::PH_HUNT;
                default:          phase_next = ahfc_pkg::PH_HUNT;
            endcase
        end
    end

    // Frame datapath and result selection.
    always_comb
    begin
        digit_pos_next = digit_pos_reg;
        hex_acc_next   = hex_acc_reg;
        run_sum_next   = run_sum_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        addr_next      = addr_reg;
        cid1_next      = cid1_reg;
        cid2_next      = cid2_reg;
        ann_len_next   = ann_len_reg;
        hex_err_next   = hex_err_reg;
        emit_info      = 1'b0;
        emit_status    = 1'b0;
        status_code    = ahfc_pkg::ST_OK;
        chk_value      = 16'd0;
        if (step)
        begin
            unique case (phase_reg)
                ahfc_pkg::PH_HUNT:
                begin
                    if (entry.is_start)
                    begin
                        digit_pos_next = 12'd0;
                        hex_acc_next   = 16'd0;
                        run_sum_next   = 16'd0;
                        major_next     = 8'd0;
                        minor_next     = 8'd0;
                        addr_next      = 8'd0;
                        cid1_next      = 8'd0;
                        cid2_next      = 8'd0;
                        ann_len_next   = 12'd0;
                        hex_err_next   = 1'b0;
                    end
                end
                ahfc_pkg::PH_VER1:
                begin
                    run_sum_next = sum_add;
                    major_next   = entry.data - ahfc_pkg::ASCII_ZERO;
                end
                ahfc_pkg::PH_VER2:
                begin
                    run_sum_next   = sum_add;
                    minor_next     = entry.data - ahfc_pkg::ASCII_ZERO;
                    digit_pos_next = 12'd0;
                end
                ahfc_pkg::PH_HDR:
                begin
                    run_sum_next = sum_add;
                    hex_acc_next = acc_shift;
                    hex_err_next = err_now;
                    priority if (digit_pos_reg == ahfc_pkg::ADDR_DIGIT)
                    begin
                        addr_next = acc_shift[7:0];
                    end
                    else if (digit_pos_reg == ahfc_pkg::CID1_DIGIT)
                    begin
                        cid1_next = acc_shift[7:0];
                    end
                    else if (digit_pos_reg == ahfc_pkg::CID2_DIGIT)
                    begin
                        cid2_next = acc_shift[7:0];
                    end
                    else
                    begin
                        addr_next = addr_reg;
                    end
                    if (hdr_done)
                    begin
                        ann_len_next = acc_shift[11:0];
                        if (err_now)
                        begin
                            emit_status = 1'b1;
                            status_code = ahfc_pkg::ST_NOT_HEX;
                        end
                        else if (len_bad)
                        begin
                            emit_status = 1'b1;
                            status_code = ahfc_pkg::ST_LEN_BAD;
                        end
                        else
                        begin
                            digit_pos_next = 12'd0;
                            hex_acc_next   = 16'd0;
                        end
                    end
                    else
                    begin
                        digit_pos_next = dp_inc;
                    end
                end
                ahfc_pkg::PH_INFO:
                begin
                    run_sum_next = sum_add;
                    emit_info    = 1'b1;
                    if (dp_inc >= ann_len_reg)
                    begin
                        digit_pos_next = 12'd0;
                        hex_acc_next   = 16'd0;
                    end
                    else
                    begin
                        digit_pos_next = dp_inc;
                    end
                end
                ahfc_pkg::PH_CHK:
                begin
                    hex_acc_next   = acc_shift;
                    hex_err_next   = err_now;
                    digit_pos_next = dp_inc;
                end
                ahfc_pkg::PH_END:
                begin
                    emit_status = 1'b1;
                    chk_value   = hex_acc_reg;
                    priority if (hex_err_reg)
                    begin
                        status_code = ahfc_pkg::ST_NOT_HEX;
                    end
                    else if (hex_acc_reg != expect_sum)
                    begin
                        status_code = ahfc_pkg::ST_CHK_BAD;
                    end
                    else if (!entry.is_cr)
                    begin
                        status_code = ahfc_pkg::ST_NO_CR;
                    end
                    else
                    begin
                        status_code = ahfc_pkg::ST_OK;
                    end
                end
                default:
                begin
                    hex_err_next = hex_err_reg;
                end
            endcase
        end
    end

    // Result register: loaded when the step makes a result, else drained.
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (emit_info)
        begin
            res_next           = '0;
            res_next.info_char = entry.data;
            res_valid_next     = 1'b1;
        end
        else if (emit_status)
        begin
            res_next.kind              = 1'b1;
            res_next.info_char         = 8'd0;
            res_next.status            = status_code;
            res_next.major_version     = major_next;
            res_next.minor_version     = minor_next;
            res_next.device_address    = addr_next;
            res_next.control_code      = cid1_next;
            res_next.command_code      = cid2_next;
            res_next.info_length       = ann_len_next;
            res_next.received_checksum = chk_value;
            res_next.frame_last        = 1'b1;
            res_valid_next             = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ahfc_pkg::PH_HUNT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Frame fields are cleared by the start character, so they need no reset.
    always_ff @(posedge clk)
    begin
        digit_pos_reg <= digit_pos_next;
        hex_acc_reg   <= hex_acc_next;
        run_sum_reg   <= run_sum_next;
        major_reg     <= major_next;
        minor_reg     <= minor_next;
        addr_reg      <= addr_next;
        cid1_reg      <= cid1_next;
        cid2_reg      <= cid2_next;
        ann_len_reg   <= ann_len_next;
        hex_err_reg   <= hex_err_next;
        res_reg       <= res_next;
    end

    assign result.valid             = res_valid_reg;
    assign result.kind              = res_reg.kind;
    assign result.info_char         = res_reg.info_char;
    assign result.status            = res_reg.status;
    assign result.major_version     = res_reg.major_version;
    assign result.minor_version     = res_reg.minor_version;
    assign result.device_address    = res_reg.device_address;
    assign result.control_code      = res_reg.control_code;
    assign result.command_code      = res_reg.command_code;
    assign result.info_length       = res_reg.info_length;
    assign result.received_checksum = res_reg.received_checksum;
    assign result.frame_last        = res_reg.frame_last;

endmodule

FILE: design/ascii_hex_frame_checker.sv
// Top level of the ASCII hex frame checker: front end, byte queue, back end.
// Depends on ahfc_pkg, ahfc_if, ahfc_front, ahfc_queue and ahfc_back.
//
// Usage. The rx channel carries one received character per request. The
// block hunts for '~', decodes the version, address, CID1, CID2 and length
// word of the header, passes every info character out as a result with kind
// 0, reads the four-digit frame checksum and closes each frame with one
// status result (kind 1, frame_last 1) on the byte after the checksum.
// Frames whose header fails the hex check or the length checksum close right
// after the length word.
// Timing. A byte accepted at a clock edge is written into the queue at that
// edge; the back end takes it from the queue once its result register is free
// or drains, and loads the result register with any result the byte makes.
// The block sustains one byte per cycle while results are taken; that rate is
// set by the back end, one queue entry per cycle whenever it can advance.
// Stalls. When the result receiver holds ready low, the result register
// holds its request and the back end stops; the queue (QueueDepth entries)
// keeps accepting bytes until it fills, then rx ready falls.
// Reset. rst_n clears the state machine to hunting, empties the queue and
// drops the result valid; no clearing pass is needed.
module ascii_hex_frame_checker #(
    parameter int QueueDepth = ahfc_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    ahfc_in_if.sink     rx,
    ahfc_out_if.source  result
);

    logic             push_valid;
    logic             push_ready;
    ahfc_pkg::entry_t push_data;
    logic             pop_valid;
    logic             pop_ready;
    ahfc_pkg::entry_t pop_data;

    // Byte classification: hex digit value, start and CR detection.
    ahfc_front u_front (
        .rx         (rx),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // The queue lets the byte side keep accepting while the result side stalls.
    ahfc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Frame state machine with the result register.
    ahfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .entry     (pop_data),
        .result    (result)
    );

endmodule

FILE: design/ahfc_checker.sv
// Port-level assertions for the ASCII hex frame checker and the bind to it.
// Depends on ascii_hex_frame_checker_assert.svh and on ahfc_pkg for the codes.
`include "ascii_hex_frame_checker_assert.svh"

module ahfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        kind,
    input logic [7:0]  info_char,
    input logic [2:0]  status,
    input logic [11:0] info_length,
    input logic [15:0] received_checksum,
    input logic        frame_last
);

    logic [40:0] held_payload;
    logic        info_clean;
    logic        status_clean;
    logic        len_bad;

    assign held_payload = {kind, info_char, status, info_length, received_checksum,
                           frame_last};
    assign info_clean   = (status == ahfc_pkg::ST_OK) && !frame_last &&
                          (info_length == 12'd0) && (received_checksum == 16'd0);
    assign status_clean = frame_last && (info_char == 8'd0) &&
                          (status <= ahfc_pkg::ST_NOT_HEX);
    assign len_bad      = (status == ahfc_pkg::ST_LEN_BAD);

    // A stalled result keeps its request and its contents.
    `AHFC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(held_payload))

    // An info result carries nothing but its character.
    `AHFC_ASSERT_IMP(a_info_clean, res_valid && !kind, info_clean)

    // A status result closes the frame with a defined code and no character.
    `AHFC_ASSERT_IMP(a_status_close, res_valid && kind, status_clean)

    // A length checksum failure ends the frame before the checksum is read.
    `AHFC_ASSERT_IMP(a_len_bad_no_chk, res_valid && kind && len_bad, received_checksum == 16'd0)

endmodule

bind ascii_hex_frame_checker ahfc_checker u_ahfc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .kind              (result.kind),
    .info_char         (result.info_char),
    .status            (result.status),
    .info_length       (result.info_length),
    .received_checksum (result.received_checksum),
    .frame_last        (result.frame_last)
);

FILE: tb/ahfc_result_checker.sv
// Result checker for the ASCII hex frame checker: decodes every accepted byte,
// queues the results it predicts and compares each accepted result with them.
// Depends on ahfc_pkg and the ahfc_in_if / ahfc_out_if channel interfaces.
module ahfc_result_checker (
    input  logic       clk,
    input  logic       rst_n,
    ahfc_in_if         rx,
    ahfc_out_if        result,
    output int         fail_count,
    output int         pending_count,
    output int         info_count,
    output int         status_count,
    output logic [4:0] status_codes_seen
);

    // Own copy of the frame decoder state.
    ahfc_pkg::phase_t  fsm;
    logic [11:0]       digit_idx;
    logic [15:0]       hex_acc;
    logic [15:0]       byte_sum;
    logic [7:0]        hdr [5];
    logic [11:0]       info_len;
    logic              hex_bad;

    ahfc_pkg::result_t predicted_results [$];
    int                mismatches = 0;
    int                n_pending = 0;
    int                n_info = 0;
    int                n_status = 0;
    int                n_results = 0;
    logic [4:0]        codes = '0;

    assign fail_count        = mismatches;
    assign pending_count     = n_pending;
    assign info_count        = n_info;
    assign status_count      = n_status;
    assign status_codes_seen = codes;

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", n_results, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
        end
    endtask

    function automatic logic [3:0] digit_value(input logic [7:0] c, output logic ok);
        ok = 1'b1;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return 4'(c - 8'h30);
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return 4'(c - 8'h41 + 8'd10);
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return 4'(c - 8'h61 + 8'd10);
        end
        ok = 1'b0;
        return 4'd0;
    endfunction

    function automatic logic [3:0] length_check(input logic [11:0] n);
        logic [5:0] s;
        s = n[3:0] + n[7:4] + n[11:8];
        return 4'd0 - s[3:0];
    endfunction

    task automatic shift_digit(input logic [7:0] c);
        logic       ok;
        logic [3:0] d;
        d = digit_value(c, ok);
        if (!ok)
        begin
            hex_bad = 1'b1;
        end
        hex_acc = {hex_acc[11:0], d};
    endtask

    task automatic close_frame(input ahfc_pkg::status_t st, input logic [15:0] chk);
        ahfc_pkg::result_t r;
        r                   = '0;
        r.kind              = 1'b1;
        r.status            = st;
        r.major_version     = hdr[0];
        r.minor_version     = hdr[1];
        r.device_address    = hdr[2];
        r.control_code      = hdr[3];
        r.command_code      = hdr[4];
        r.info_length       = info_len;
        r.received_checksum = chk;
        r.frame_last        = 1'b1;
        predicted_results.push_back(r);
        fsm = ahfc_pkg::PH_HUNT;
    endtask

    task automatic decode_rx_byte(input logic [7:0] c);
        ahfc_pkg::result_t r;
        ahfc_pkg::status_t st;
        case (fsm)
            ahfc_pkg::PH_HUNT:
            begin
                if (c == ahfc_pkg::START_CHAR)
                begin
                    fsm       = ahfc_pkg::PH_VER1;
                    digit_idx = '0;
                    hex_acc   = '0;
                    byte_sum  = '0;
                    foreach (hdr[k]) hdr[k] = '0;
                    info_len  = '0;
                    hex_bad   = 1'b0;
                end
            end
            ahfc_pkg::PH_VER1:
            begin
                byte_sum += c;
                hdr[0]    = c - ahfc_pkg::ASCII_ZERO;
                fsm       = ahfc_pkg::PH_VER2;
            end
            ahfc_pkg::PH_VER2:
            begin
                byte_sum += c;
                hdr[1]    = c - ahfc_pkg::ASCII_ZERO;
                fsm       = ahfc_pkg::PH_HDR;
                digit_idx = '0;
            end
            ahfc_pkg::PH_HDR:
            begin
                byte_sum += c;
                shift_digit(c);
                if (digit_idx == ahfc_pkg::ADDR_DIGIT) hdr[2] = hex_acc[7:0];
                else if (digit_idx == ahfc_pkg::CID1_DIGIT) hdr[3] = hex_acc[7:0];
                else if (digit_idx == ahfc_pkg::CID2_DIGIT) hdr[4] = hex_acc[7:0];
                if (digit_idx >= ahfc_pkg::HDR_LAST_DIGIT)
                begin
                    info_len = hex_acc[11:0];
                    if (hex_bad)
                    begin
                        close_frame(ahfc_pkg::ST_NOT_HEX, 16'd0);
                    end
                    else if (hex_acc[15:12] != length_check(info_len))
                    begin
                        close_frame(ahfc_pkg::ST_LEN_BAD, 16'd0);
                    end
                    else
                    begin
                        digit_idx = '0;
                        hex_acc   = '0;
                        fsm       = (info_len == 12'd0) ? ahfc_pkg::PH_CHK
                                                        : ahfc_pkg::PH_INFO;
                    end
                end
                else
                begin
                    digit_idx++;
                end
            end
            ahfc_pkg::PH_INFO:
            begin
                byte_sum   += c;
                r           = '0;
                r.info_char = c;
                predicted_results.push_back(r);
                digit_idx++;
                if (digit_idx >= info_len)
                begin
                    digit_idx = '0;
                    hex_acc   = '0;
                    fsm       = ahfc_pkg::PH_CHK;
                end
            end
            ahfc_pkg::PH_CHK:
            begin
                shift_digit(c);
                digit_idx++;
                if (digit_idx >= ahfc_pkg::CHK_DIGITS)
                begin
                    fsm = ahfc_pkg::PH_END;
                end
            end
            ahfc_pkg::PH_END:
            begin
                if (hex_bad) st = ahfc_pkg::ST_NOT_HEX;
                else if (hex_acc != 16'd0 - byte_sum) st = ahfc_pkg::ST_CHK_BAD;
                else if (c != ahfc_pkg::CR_CHAR) st = ahfc_pkg::ST_NO_CR;
                else st = ahfc_pkg::ST_OK;
                close_frame(st, hex_acc);
            end
            default:
            begin
                fsm = ahfc_pkg::PH_HUNT;
            end
        endcase
    endtask

    task automatic check_result();
        ahfc_pkg::result_t want;
        n_results++;
        if (predicted_results.size() == 0)
        begin
            report_mismatch("result arrived with nothing predicted");
            return;
        end
        want = predicted_results.pop_front();
        compare_field("kind", result.kind, want.kind);
        compare_field("info_char", result.info_char, want.info_char);
        compare_field("status", result.status, want.status);
        compare_field("major_version", result.major_version, want.major_version);
        compare_field("minor_version", result.minor_version, want.minor_version);
        compare_field("device_address", result.device_address, want.device_address);
        compare_field("control_code", result.control_code, want.control_code);
        compare_field("command_code", result.command_code, want.command_code);
        compare_field("info_length", result.info_length, want.info_length);
        compare_field("received_checksum", result.received_checksum,
                      want.received_checksum);
        compare_field("frame_last", result.frame_last, want.frame_last);
        if (want.kind)
        begin
            n_status++;
            codes[want.status] = 1'b1;
        end
        else
        begin
            n_info++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm       = ahfc_pkg::PH_HUNT;
            digit_idx = '0;
            hex_acc   = '0;
            byte_sum  = '0;
            foreach (hdr[k]) hdr[k] = '0;
            info_len  = '0;
            hex_bad   = 1'b0;
            predicted_results.delete();
            n_pending = 0;
        end
        else
        begin
            // A byte's own result cannot appear at its acceptance edge, so the
            // compare goes first.
            if (result.valid && result.ready)
            begin
                check_result();
            end
            if (rx.valid && rx.ready)
            begin
                decode_rx_byte(rx.rx_byte);
            end
            n_pending = predicted_results.size();
        end
    end

endmodule

FILE: tb/ascii_hex_frame_checker_tb.sv
// Top of the testbench for the ASCII hex frame checker: clock, reset, byte
// stimulus, result receiver and verdict. Depends on ahfc_pkg, the channel
// interfaces, the block itself and the ahfc_result_checker module.
module ascii_hex_frame_checker_tb;

    // Frames are generated whole and then fed in byte by byte. Each frame
    // carries at most one fault, chosen from the list below.
    typedef enum int {
        FRAME_CLEAN,
        FRAME_LEN_BAD,
        FRAME_HDR_HEX,
        FRAME_CHK_BAD,
        FRAME_CHK_HEX,
        FRAME_NO_CR,
        FRAME_CUT
    } frame_fault_t;

    localparam int RANDOM_ITEMS = 1950;
    localparam int LONG_HOLD    = 120;
    localparam int TAIL_CYCLES  = 10;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;

    ahfc_in_if  rx_ch ();
    ahfc_out_if res_ch ();

    int         fail_count;
    int         pending_count;
    int         info_count;
    int         status_count;
    logic [4:0] status_codes_seen;

    // Shared between the sender and the receiver: calm turns off idling on
    // both sides, long_hold asks the receiver for one long stall.
    bit         calm = 1'b0;
    bit         long_hold = 1'b0;
    int         bytes_sent = 0;
    int         frames_sent = 0;
    int         cycle_count = 0;

    logic [7:0]  frame_bytes [$];
    logic [15:0] body_sum;

    ascii_hex_frame_checker u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    ahfc_result_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .rx                (rx_ch),
        .result            (res_ch),
        .fail_count        (fail_count),
        .pending_count     (pending_count),
        .info_count        (info_count),
        .status_count      (status_count),
        .status_codes_seen (status_codes_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a run that is still going at the limit has hung somewhere.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return ahfc_pkg::ASCII_ZERO + n;
        end
        return (lower ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_hex(c)) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [3:0] length_nibble(input logic [11:0] n);
        logic [5:0] s;
        s = n[3:0] + n[7:4] + n[11:8];
        return 4'd0 - s[3:0];
    endfunction

    // Every byte between the start character and the frame checksum goes into the frame sum.
    task automatic put_byte(input logic [7:0] b);
        frame_bytes.push_back(b);
        body_sum += b;
    endtask

    // Builds one frame into frame_bytes. The length checksum and the frame
    // checksum are computed from what is actually put into the frame, then
    // spoiled on purpose where the fault asks for it. Frames with a header
    // fault stop after the length word, since the block closes them there.
    task automatic build_frame(input logic [11:0] len, input frame_fault_t fault,
                               input bit lower, input bit odd_version,
                               input logic [7:0] addr, input logic [7:0] cid1,
                               input logic [7:0] cid2);
        logic [7:0]  digits [10];
        logic [7:0]  chk_digits [4];
        logic [3:0]  lc;
        logic [15:0] word;
        logic [15:0] good_chk;
        logic [15:0] chk;
        int          keep;
        frame_bytes.delete();
        body_sum = '0;
        frame_bytes.push_back(ahfc_pkg::START_CHAR);
        put_byte(odd_version ? 8'($urandom_range(0, 255)) : ahfc_pkg::ASCII_ZERO + 8'd2);
        put_byte(odd_version ? 8'($urandom_range(0, 255)) : ahfc_pkg::ASCII_ZERO + 8'd1);
        lc = length_nibble(len);
        if (fault == FRAME_LEN_BAD)
        begin
            lc = lc ^ 4'($urandom_range(1, 15));
        end
        word = {lc, len};
        digits[0] = hex_char(addr[7:4], lower);
        digits[1] = hex_char(addr[3:0], lower);
        digits[2] = hex_char(cid1[7:4], lower);
        digits[3] = hex_char(cid1[3:0], lower);
        digits[4] = hex_char(cid2[7:4], lower);
        digits[5] = hex_char(cid2[3:0], lower);
        for (int k = 0; k < 4; k++)
        begin
            digits[6 + k] = hex_char(word[15 - 4 * k -: 4], lower);
        end
        if (fault == FRAME_HDR_HEX)
        begin
            digits[$urandom_range(0, 9)] = non_hex_char();
        end
        foreach (digits[k]) put_byte(digits[k]);
        if (fault == FRAME_LEN_BAD || fault == FRAME_HDR_HEX)
        begin
            return;
        end
        // Info characters are fully random, so stray start characters and
        // carriage returns show up inside the info field as well.
        for (int k = 0; k < len; k++)
        begin
            put_byte(8'($urandom_range(0, 255)));
        end
        good_chk = 16'd0 - body_sum;
        chk      = good_chk;
        if (fault == FRAME_CHK_BAD)
        begin
            case ($urandom_range(0, 2))
                0: chk = 16'h0000;
                1: chk = 16'hFFFF;
                default: chk = good_chk ^ 16'($urandom_range(1, 65535));
            endcase
            if (chk == good_chk)
            begin
                chk[0] = ~chk[0];
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            chk_digits[k] = hex_char(chk[15 - 4 * k -: 4], lower);
        end
        if (fault == FRAME_CHK_HEX)
        begin
            chk_digits[$urandom_range(0, 3)] = non_hex_char();
        end
        foreach (chk_digits[k]) frame_bytes.push_back(chk_digits[k]);
        if (fault == FRAME_NO_CR)
        begin
            frame_bytes.push_back(8'($urandom_range(0, 255)) ^ ahfc_pkg::CR_CHAR ^
                                  8'($urandom_range(1, 255)) ^ 8'd0);
            if (frame_bytes[$] == ahfc_pkg::CR_CHAR)
            begin
                frame_bytes[$] = 8'h0A;
            end
        end
        else
        begin
            frame_bytes.push_back(ahfc_pkg::CR_CHAR);
        end
        // A cut frame leaves the block mid-frame; whatever follows is then
        // taken as part of it, start characters included.
        if (fault == FRAME_CUT)
        begin
            keep = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
        end
    endtask

    // Offers one request and returns in the step of its acceptance edge, so
    // the caller always updates valid in that same step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        repeat (gap)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
        frames_sent++;
    endtask

    // Stops offering until every predicted result has been taken.
    task automatic pause_until_drained();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // Result receiver. Before each result it draws a gap with ready low; when
    // asked it holds ready low for a long stretch instead, which backs the
    // block up until it refuses further bytes.
    initial
    begin
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                gap = calm ? 0 : $urandom_range(0, 5);
                repeat (gap)
                begin
                    res_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
        end
    end

    // Main stimulus: reset, a short directed part, then random frames.
    initial
    begin
        int           f;
        int           random_bytes;
        logic [11:0]  len;
        frame_fault_t fault;
        logic [7:0]   noise;

        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extreme bytes and a carriage return while hunting, then
        // a well-formed frame with an empty info field, so the checksum
        // follows the length word at once and the length nibble sum is zero.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ahfc_pkg::CR_CHAR);
        build_frame(12'd0, FRAME_CLEAN, 1'b1, 1'b0, 8'hFF, 8'h00, 8'hA5);
        send_frame();

        // Random part: frames with random content, just under half of them
        // well-formed and the rest carrying one fault each, with some noise between frames.
        f            = 0;
        random_bytes = 0;
        while (random_bytes < RANDOM_ITEMS)
        begin
            // A few frames with no idling on either side.
            calm = (f >= 20 && f < 26);
            if (f == 8 || f == 50)
            begin
                // A long info field under a long receiver stall fills the
                // block's queue and stalls its input.
                long_hold = 1'b1;
                len       = 12'd60;
                fault     = FRAME_CLEAN;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1:    len = 12'd0;
                    17, 18:  len = 12'($urandom_range(17, 64));
                    19:      len = 12'($urandom_range(65, 200));
                    default: len = 12'($urandom_range(1, 16));
                endcase
                case ($urandom_range(0, 19))
                    10:      fault = FRAME_LEN_BAD;
                    11, 12:  fault = FRAME_HDR_HEX;
                    13, 14:  fault = FRAME_CHK_BAD;
                    15, 16:  fault = FRAME_CHK_HEX;
                    17, 18:  fault = FRAME_NO_CR;
                    19:      fault = FRAME_CUT;
                    default: fault = FRAME_CLEAN;
                endcase
                if ($urandom_range(0, 19) == 0)
                begin
                    fault = FRAME_LEN_BAD;
                end
                // Header faults end the frame before any info, so the
                // largest length word costs nothing there.
                if ((fault == FRAME_LEN_BAD || fault == FRAME_HDR_HEX) &&
                    $urandom_range(0, 2) == 0)
                begin
                    len = 12'hFFF;
                end
            end
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    noise = 8'($urandom_range(0, 255));
                    if (noise == ahfc_pkg::START_CHAR)
                    begin
                        noise = 8'h20;
                    end
                    send_byte(noise);
                end
            end
            build_frame(len, fault, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0,
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
            random_bytes += frame_bytes.size();
            send_frame();
            if (f % 16 == 15)
            begin
                pause_until_drained();
            end
            f++;
        end
        calm = 1'b0;

        // Let the last results drain, then a few more cycles so that any
        // result nobody predicted has time to show up.
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d frames in %0d requests: %0d info and %0d status results",
                 frames_sent, bytes_sent, info_count, status_count);
        $display("status codes seen (bit per code): %b, %0d mismatches",
                 status_codes_seen, fail_count);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/ahfc_pkg.sv
design/ahfc_if.sv
design/ahfc_front.sv
design/ahfc_queue.sv
design/ahfc_back.sv
design/ascii_hex_frame_checker.sv
design/ahfc_checker.sv
tb/ahfc_result_checker.sv
tb/ascii_hex_frame_checker_tb.sv
